### sv/xct_pkg.sv
// ----------------------------------------------------------------------------
// xct_pkg
// Types, codes and byte classification helpers for the XML byte tokenizer.
// ----------------------------------------------------------------------------
package xct_pkg;

	localparam int OFFSET_WIDTH = 24;
	localparam int LINE_WIDTH   = 20;

	typedef logic [OFFSET_WIDTH-1:0] offset_t;
	typedef logic [LINE_WIDTH-1:0]   line_t;
	typedef logic [4:0]              kind_t;

	localparam offset_t OFS_MAX  = {OFFSET_WIDTH{1'b1}};
	localparam line_t   LINE_MAX = {LINE_WIDTH{1'b1}};

	// token kinds
	localparam kind_t K_LT      = 5'd0;
	localparam kind_t K_GT      = 5'd1;
	localparam kind_t K_QM      = 5'd2;
	localparam kind_t K_EXCL    = 5'd3;
	localparam kind_t K_SLASH   = 5'd4;
	localparam kind_t K_EQ      = 5'd5;
	localparam kind_t K_SQ      = 5'd6;
	localparam kind_t K_DQ      = 5'd7;
	localparam kind_t K_LBRK    = 5'd8;
	localparam kind_t K_RBRK    = 5'd9;
	localparam kind_t K_LPAR    = 5'd10;
	localparam kind_t K_RPAR    = 5'd11;
	localparam kind_t K_COMMA   = 5'd12;
	localparam kind_t K_PLUS    = 5'd13;
	localparam kind_t K_MINUS   = 5'd14;
	localparam kind_t K_HASH    = 5'd15;
	localparam kind_t K_PIPE    = 5'd16;
	localparam kind_t K_STAR    = 5'd17;
	localparam kind_t K_AMP     = 5'd18;
	localparam kind_t K_PCT     = 5'd19;
	localparam kind_t K_SEMI    = 5'd20;
	localparam kind_t K_IDENT   = 5'd21;
	localparam kind_t K_STRING  = 5'd22;
	localparam kind_t K_ERROR   = 5'd23;

	// lexer modes
	localparam logic [1:0] MODE_DEFAULT = 2'd0;
	localparam logic [1:0] MODE_STRING  = 2'd1;
	localparam logic [1:0] MODE_TEXT    = 2'd2;

	// closing delimiters
	localparam logic [1:0] DELIM_NONE = 2'd0;
	localparam logic [1:0] DELIM_SQ   = 2'd1;
	localparam logic [1:0] DELIM_DQ   = 2'd2;
	localparam logic [1:0] DELIM_LT   = 2'd3;

	// characters of interest
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_USCR  = 8'h5F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		kind_t      tok_kind;
		line_t      line_number;
		offset_t    start_offset;
		offset_t    lexeme_length;
		logic [7:0] bad_char;
		logic       last_of_run;
	} token_t;

	function automatic logic is_ident_start(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
			|| c == CH_USCR || c == CH_COLON;
	endfunction

	function automatic logic is_ident_char(input logic [7:0] c);
		return is_ident_start(c) || (c >= 8'h30 && c <= 8'h39)
			|| c == CH_DASH || c == CH_DOT;
	endfunction

	// punctuation lookup: valid flag and kind
	function automatic logic [5:0] punct_lookup(input logic [7:0] c);
		logic [5:0] r;
		r = 6'd0;
		case (c)
			CH_LT:   r = {1'b1, K_LT};
			CH_GT:   r = {1'b1, K_GT};
			8'h3F:   r = {1'b1, K_QM};
			8'h21:   r = {1'b1, K_EXCL};
			8'h2F:   r = {1'b1, K_SLASH};
			8'h3D:   r = {1'b1, K_EQ};
			CH_SQ:   r = {1'b1, K_SQ};
			CH_DQ:   r = {1'b1, K_DQ};
			8'h5B:   r = {1'b1, K_LBRK};
			8'h5D:   r = {1'b1, K_RBRK};
			8'h28:   r = {1'b1, K_LPAR};
			8'h29:   r = {1'b1, K_RPAR};
			8'h2C:   r = {1'b1, K_COMMA};
			8'h2B:   r = {1'b1, K_PLUS};
			CH_DASH: r = {1'b1, K_MINUS};
			8'h23:   r = {1'b1, K_HASH};
			8'h7C:   r = {1'b1, K_PIPE};
			8'h2A:   r = {1'b1, K_STAR};
			8'h26:   r = {1'b1, K_AMP};
			8'h25:   r = {1'b1, K_PCT};
			8'h3B:   r = {1'b1, K_SEMI};
			default: r = 6'd0;
		endcase
		return r;
	endfunction

	// length of a run from start to pos, plus the current byte when incl is set
	function automatic offset_t run_len(input offset_t pos, input offset_t start,
			input logic incl);
		offset_t diff;
		offset_t len;
		diff = pos - start;
		if (pos < start) begin
			len = offset_t'(1);
		end else if (incl) begin
			len = (diff == OFS_MAX) ? OFS_MAX : diff + offset_t'(1);
		end else begin
			len = (diff == '0) ? offset_t'(1) : diff;
		end
		return len;
	endfunction

endpackage

### sv/xml_character_tokenizer.sv
// ----------------------------------------------------------------------------
// xml_character_tokenizer
// Byte-at-a-time XML tokenizer with a four-entry token queue on the output.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------------
//  input   | item_valid / item_ready    | item  (char_in, end_of_text)
//  output  | token_valid / token_ready  | token (kind, line, start, length,
//          |                            |        bad_char, last_of_run)
//
//  one byte is accepted per cycle while item_ready is high; its zero, one or two
//  tokens enter the output queue at the same edge and leave one per cycle while token_ready is high
//  item_ready is high while the queue has room for two tokens
//  a stalled output side fills the queue and then holds off the input
//  reset returns the lexer to default mode at line 1, offset 0, queue empty
// ----------------------------------------------------------------------------
module xml_character_tokenizer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  xct_pkg::in_item_t item,
	output logic              token_valid,
	input  logic              token_ready,
	output xct_pkg::token_t   token
);
	import xct_pkg::*;

	// lexer state
	logic [1:0] mode_q;
	logic [1:0] delim_q;
	logic       run_open_q;
	logic       run_ident_q;
	offset_t    run_start_q;
	offset_t    pos_q;
	line_t      line_q;

	// output queue
	token_t     fifo_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;

	logic       accept;
	logic       pop;
	logic [7:0] c;
	logic       eot;
	logic [7:0] dch;
	logic       special;
	line_t      line_nx;
	logic [5:0] pl;
	logic       consumed;

	logic       a_vld, b_vld, c_vld;
	token_t     a_tok, b_tok, c_tok;
	token_t     t0, t1;
	logic [1:0] n_push;

	logic [1:0] mode_nx;
	logic [1:0] delim_nx;
	logic       open_nx;
	logic       ident_nx;
	offset_t    start_nx;

	assign c      = item.char_in;
	assign eot    = item.end_of_text;
	assign accept = item_valid && item_ready;
	assign pop    = token_valid && token_ready;

	assign item_ready  = count_q <= 3'd2;
	assign token_valid = count_q != 3'd0;
	assign token       = fifo_q[rd_ptr_q];

	// closing delimiter byte and mode decode
	always_comb begin
		case (delim_q)
			DELIM_SQ: dch = CH_SQ;
			DELIM_DQ: dch = CH_DQ;
			DELIM_LT: dch = CH_LT;
			default:  dch = 8'h00;
		endcase
	end

	assign special = (mode_q == MODE_STRING || mode_q == MODE_TEXT) && delim_q != DELIM_NONE;
	assign line_nx = (c == CH_NL && line_q != LINE_MAX) ? line_q + line_t'(1) : line_q;
	assign pl      = punct_lookup(c);

	// byte classification and state update
	always_comb begin
		a_vld    = 1'b0;
		b_vld    = 1'b0;
		a_tok    = '0;
		b_tok    = '0;
		consumed = 1'b0;
		mode_nx  = mode_q;
		delim_nx = delim_q;
		open_nx  = run_open_q;
		ident_nx = run_ident_q;
		start_nx = run_start_q;

		a_tok.line_number   = line_nx;
		a_tok.start_offset  = run_start_q;
		a_tok.lexeme_length = run_len(pos_q, run_start_q, 1'b0);
		a_tok.tok_kind      = run_ident_q ? K_IDENT : K_STRING;
		b_tok.line_number   = line_nx;
		b_tok.start_offset  = pos_q;
		b_tok.lexeme_length = offset_t'(1);

		if (special) begin
			if (c == dch) begin
				a_vld = run_open_q;
				a_tok.tok_kind = K_STRING;
				b_vld = 1'b1;
				case (delim_q)
					DELIM_LT: b_tok.tok_kind = K_LT;
					DELIM_DQ: b_tok.tok_kind = K_DQ;
					default:  b_tok.tok_kind = K_SQ;
				endcase
				mode_nx  = MODE_DEFAULT;
				delim_nx = DELIM_NONE;
				open_nx  = 1'b0;
				ident_nx = 1'b0;
			end else if (!run_open_q) begin
				open_nx  = 1'b1;
				ident_nx = 1'b0;
				start_nx = pos_q;
			end
		end else begin
			consumed = run_open_q && run_ident_q && is_ident_char(c);
			if (run_open_q && !consumed) begin
				a_vld    = 1'b1;
				open_nx  = 1'b0;
				ident_nx = 1'b0;
			end
			if (!consumed) begin
				if (pl[5]) begin
					b_vld = 1'b1;
					b_tok.tok_kind = pl[4:0];
					if (c == CH_GT) begin
						mode_nx  = MODE_TEXT;
						delim_nx = DELIM_LT;
					end else if (c == CH_SQ) begin
						mode_nx  = MODE_STRING;
						delim_nx = DELIM_SQ;
					end else if (c == CH_DQ) begin
						mode_nx  = MODE_STRING;
						delim_nx = DELIM_DQ;
					end
				end else if (c == CH_SPACE || c == CH_NL) begin
					b_vld = 1'b0;
				end else if (is_ident_start(c)) begin
					open_nx  = 1'b1;
					ident_nx = 1'b1;
					start_nx = pos_q;
				end else begin
					b_vld = 1'b1;
					b_tok.tok_kind = K_ERROR;
					b_tok.bad_char = c;
				end
			end
		end
	end

	// flush of an open run at end of text
	always_comb begin
		c_vld = eot && open_nx;
		c_tok = '0;
		c_tok.tok_kind      = ident_nx ? K_IDENT : K_STRING;
		c_tok.line_number   = line_nx;
		c_tok.start_offset  = start_nx;
		c_tok.lexeme_length = run_len(pos_q, start_nx, 1'b1);
	end

	// pack the first two tokens of this byte, mark the last one
	always_comb begin
		t0 = a_tok;
		t1 = b_tok;
		n_push = 2'd0;
		if (a_vld) begin
			t0 = a_tok;
			if (b_vld) begin
				t1 = b_tok;
				n_push = 2'd2;
			end else if (c_vld) begin
				t1 = c_tok;
				n_push = 2'd2;
			end else begin
				n_push = 2'd1;
			end
		end else if (b_vld) begin
			t0 = b_tok;
			if (c_vld) begin
				t1 = c_tok;
				n_push = 2'd2;
			end else begin
				n_push = 2'd1;
			end
		end else if (c_vld) begin
			t0 = c_tok;
			n_push = 2'd1;
		end
		t0.last_of_run = (n_push == 2'd1);
		t1.last_of_run = 1'b1;
	end

	// lexer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_DEFAULT;
			delim_q     <= DELIM_NONE;
			run_open_q  <= 1'b0;
			run_ident_q <= 1'b0;
			run_start_q <= '0;
			pos_q       <= '0;
			line_q      <= line_t'(1);
		end else if (accept) begin
			if (eot) begin
				mode_q      <= MODE_DEFAULT;
				delim_q     <= DELIM_NONE;
				run_open_q  <= 1'b0;
				run_ident_q <= 1'b0;
				run_start_q <= '0;
				pos_q       <= '0;
				line_q      <= line_t'(1);
			end else begin
				mode_q      <= mode_nx;
				delim_q     <= delim_nx;
				run_open_q  <= open_nx;
				run_ident_q <= ident_nx;
				run_start_q <= start_nx;
				pos_q       <= (pos_q == OFS_MAX) ? OFS_MAX : pos_q + offset_t'(1);
				line_q      <= line_nx;
			end
		end
	end

	// queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + n_push;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + (accept ? {1'b0, n_push} : 3'd0) - {2'b00, pop};
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (accept && n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= t0;
		end
		if (accept && n_push == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= t1;
		end
	end

endmodule

### bench/xct_token_checker.sv
// ----------------------------------------------------------------------------
// xct_token_checker
// Watches both channels of the XML byte tokenizer, predicts the tokens of
// every accepted byte and compares each token leaving the block, field by
// field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module xct_token_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  xct_pkg::in_item_t item,
	input  logic              token_valid,
	input  logic              token_ready,
	input  xct_pkg::token_t   token,
	output int                fail_count,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import xct_pkg::*;

	// lexer state of the predictor
	logic [1:0] mode_q;
	logic [1:0] delim_q;
	logic       run_open_q;
	logic       run_ident_q;
	offset_t    run_start_q;
	offset_t    position_q;
	line_t      line_q;

	token_t expected_tokens[$];
	token_t step_tokens[$];
	int     errors;

	function automatic logic name_start(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_USCR
			|| c == CH_COLON;
	endfunction

	function automatic logic name_byte(input logic [7:0] c);
		return name_start(c) || (c >= "0" && c <= "9") || c == CH_DASH || c == CH_DOT;
	endfunction

	// bytes from start up to pos, saturating, never below one
	function automatic offset_t span_length(input offset_t pos, input offset_t start,
			input logic incl);
		logic [OFFSET_WIDTH:0] len;
		if (pos < start) begin
			return offset_t'(1);
		end
		len = {1'b0, pos - start} + {{OFFSET_WIDTH{1'b0}}, incl};
		if (len > {1'b0, OFS_MAX}) begin
			return OFS_MAX;
		end
		if (len == '0) begin
			return offset_t'(1);
		end
		return len[OFFSET_WIDTH-1:0];
	endfunction

	task automatic reset_lexer();
		mode_q      = MODE_DEFAULT;
		delim_q     = DELIM_NONE;
		run_open_q  = 1'b0;
		run_ident_q = 1'b0;
		run_start_q = '0;
		position_q  = '0;
		line_q      = line_t'(1);
	endtask

	task automatic push_token(input kind_t kind, input offset_t start, input offset_t len,
			input logic [7:0] bad);
		token_t t;
		t.tok_kind      = kind;
		t.line_number   = line_q;
		t.start_offset  = start;
		t.lexeme_length = len;
		t.bad_char      = bad;
		t.last_of_run   = 1'b0;
		if (step_tokens.size() < 2) begin
			step_tokens.push_back(t);
		end
	endtask

	// tokens caused by one byte
	task automatic predict_tokens(input in_item_t it);
		logic [7:0] c;
		logic [7:0] closer;
		kind_t      closer_kind;
		logic       delimited;
		logic       taken;
		logic       is_punct;
		kind_t      pk;
		offset_t    pos;
		c = it.char_in;
		pos = position_q;
		step_tokens.delete();
		case (delim_q)
			DELIM_SQ: begin
				closer = CH_SQ;
				closer_kind = K_SQ;
			end
			DELIM_DQ: begin
				closer = CH_DQ;
				closer_kind = K_DQ;
			end
			DELIM_LT: begin
				closer = CH_LT;
				closer_kind = K_LT;
			end
			default: begin
				closer = 8'h00;
				closer_kind = K_ERROR;
			end
		endcase
		delimited = (mode_q == MODE_STRING || mode_q == MODE_TEXT) && closer != 8'h00;

		// newline counts before any token of this byte
		if (c == CH_NL && line_q != LINE_MAX) begin
			line_q = line_q + line_t'(1);
		end

		if (delimited) begin
			// string or text mode: everything but the closer joins the run
			if (c == closer) begin
				if (run_open_q) begin
					push_token(K_STRING, run_start_q, span_length(pos, run_start_q, 1'b0),
						8'h00);
				end
				push_token(closer_kind, pos, offset_t'(1), 8'h00);
				mode_q      = MODE_DEFAULT;
				delim_q     = DELIM_NONE;
				run_open_q  = 1'b0;
				run_ident_q = 1'b0;
			end else if (!run_open_q) begin
				run_open_q  = 1'b1;
				run_ident_q = 1'b0;
				run_start_q = pos;
			end
		end else begin
			// default mode: close a run that this byte does not extend
			taken = 1'b0;
			if (run_open_q) begin
				if (run_ident_q && name_byte(c)) begin
					taken = 1'b1;
				end else begin
					push_token(run_ident_q ? K_IDENT : K_STRING, run_start_q,
						span_length(pos, run_start_q, 1'b0), 8'h00);
					run_open_q  = 1'b0;
					run_ident_q = 1'b0;
				end
			end
			if (!taken) begin
				is_punct = 1'b1;
				pk = K_ERROR;
				case (c)
					CH_LT:   pk = K_LT;
					CH_GT:   pk = K_GT;
					"?":     pk = K_QM;
					"!":     pk = K_EXCL;
					"/":     pk = K_SLASH;
					"=":     pk = K_EQ;
					CH_SQ:   pk = K_SQ;
					CH_DQ:   pk = K_DQ;
					"[":     pk = K_LBRK;
					"]":     pk = K_RBRK;
					"(":     pk = K_LPAR;
					")":     pk = K_RPAR;
					",":     pk = K_COMMA;
					"+":     pk = K_PLUS;
					CH_DASH: pk = K_MINUS;
					"#":     pk = K_HASH;
					"|":     pk = K_PIPE;
					"*":     pk = K_STAR;
					"&":     pk = K_AMP;
					"%":     pk = K_PCT;
					";":     pk = K_SEMI;
					default: is_punct = 1'b0;
				endcase
				if (is_punct) begin
					push_token(pk, pos, offset_t'(1), 8'h00);
					if (c == CH_GT) begin
						mode_q  = MODE_TEXT;
						delim_q = DELIM_LT;
					end else if (c == CH_SQ) begin
						mode_q  = MODE_STRING;
						delim_q = DELIM_SQ;
					end else if (c == CH_DQ) begin
						mode_q  = MODE_STRING;
						delim_q = DELIM_DQ;
					end
				end else if (c == CH_SPACE || c == CH_NL) begin
					// whitespace is dropped
				end else if (name_start(c)) begin
					run_open_q  = 1'b1;
					run_ident_q = 1'b1;
					run_start_q = pos;
				end else begin
					push_token(K_ERROR, pos, offset_t'(1), c);
				end
			end
		end

		// end of text flushes an open run including this byte, then restarts
		if (it.end_of_text) begin
			if (run_open_q) begin
				push_token(run_ident_q ? K_IDENT : K_STRING, run_start_q,
					span_length(pos, run_start_q, 1'b1), 8'h00);
			end
			reset_lexer();
		end else if (pos != OFS_MAX) begin
			position_q = pos + offset_t'(1);
		end

		if (step_tokens.size() > 0) begin
			step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
		end
		foreach (step_tokens[i]) begin
			expected_tokens.push_back(step_tokens[i]);
		end
	endtask

	task automatic report_field(input string field, input logic [31:0] exp,
			input logic [31:0] act);
		if (exp !== act) begin
			$display("%0t: token %s mismatch, expected %0h, actual %0h", $time, field,
				exp, act);
			errors++;
		end
	endtask

	// compare leaving tokens, then predict for the accepted byte
	always @(posedge clk or negedge arst_n) begin
		token_t want;
		if (!arst_n) begin
			reset_lexer();
			expected_tokens.delete();
			errors = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (token_valid && token_ready) begin
				if (expected_tokens.size() == 0) begin
					$display("%0t: token with no expectation, expected none, actual %0h",
						$time, token);
					errors++;
				end else begin
					want = expected_tokens.pop_front();
					report_field("tok_kind", want.tok_kind, token.tok_kind);
					report_field("line_number", want.line_number, token.line_number);
					report_field("start_offset", want.start_offset, token.start_offset);
					report_field("lexeme_length", want.lexeme_length, token.lexeme_length);
					report_field("bad_char", want.bad_char, token.bad_char);
					report_field("last_of_run", want.last_of_run, token.last_of_run);
				end
			end
			if (item_valid && item_ready) begin
				predict_tokens(item);
			end
			pending <= expected_tokens.size();
			fail_count <= errors;
		end
	end

endmodule

### bench/xml_character_tokenizer_test.sv
// ----------------------------------------------------------------------------
// xml_character_tokenizer_test
// Feeds the XML byte tokenizer directed bytes and then random XML-like texts
// with random idle on both channels, long output stalls and a full drain;
// the token checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module xml_character_tokenizer_test;
	timeunit 1ns;
	timeprecision 1ps;
	import xct_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     item_valid;
	logic     item_ready;
	in_item_t item;
	logic     token_valid;
	logic     token_ready;
	token_t   token;
	int       failures;
	int       pending;

	int          items_sent;
	int          tokens_taken;
	logic [7:0]  text_q[$];
	string       punct_set;

	xml_character_tokenizer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token      (token)
	);

	xct_token_checker tok_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token      (token),
		.fail_count (failures),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// idle cycles before an item; every fourth stretch of 128 bytes runs flat out
	function automatic int draw_idle();
		if (((items_sent >> 7) % 4) == 3) begin
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	task automatic send_byte(input in_item_t it);
		int idle;
		idle = draw_idle();
		if (idle > 0) begin
			item_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		items_sent++;
		// one full drain in the middle of the run
		if (items_sent == 600) begin
			item_valid <= 1'b0;
			do @(posedge clk); while (pending != 0);
		end
	endtask

	task automatic queue_string(input string s);
		for (int i = 0; i < s.len(); i++) begin
			text_q.push_back(s[i]);
		end
	endtask

	// send the queued text, end_of_text on its last byte
	task automatic flush_text();
		in_item_t it;
		for (int i = 0; i < text_q.size(); i++) begin
			it.char_in = text_q[i];
			it.end_of_text = (i == text_q.size() - 1);
			send_byte(it);
		end
		text_q.delete();
	endtask

	task automatic append_name();
		int n;
		int pick;
		n = $urandom_range(1, 5);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, (i == 0) ? 3 : 6);
			case (pick)
				0, 1: text_q.push_back(8'("a" + $urandom_range(0, 25)));
				2: text_q.push_back(8'("A" + $urandom_range(0, 25)));
				3: text_q.push_back($urandom_range(0, 1) ? CH_USCR : CH_COLON);
				4: text_q.push_back(8'("0" + $urandom_range(0, 9)));
				5: text_q.push_back($urandom_range(0, 1) ? CH_DASH : CH_DOT);
				default: text_q.push_back(8'("a" + $urandom_range(0, 25)));
			endcase
		end
	endtask

	// random content, mostly avoiding the byte that would close it
	task automatic append_body(input logic [7:0] stop);
		int n;
		logic [7:0] b;
		n = $urandom_range(0, 6);
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom_range(0, 255));
			if (b == stop && $urandom_range(0, 15) != 0) begin
				b = "x";
			end
			text_q.push_back(b);
		end
	endtask

	task automatic append_fragment();
		int n;
		logic [7:0] q;
		case ($urandom_range(0, 9))
			// element with attributes, text content and closing tag
			0, 1, 2, 3, 4, 5: begin
				queue_string("<");
				append_name();
				n = $urandom_range(0, 2);
				for (int i = 0; i < n; i++) begin
					queue_string(" ");
					append_name();
					queue_string("=");
					q = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
					text_q.push_back(q);
					append_body(q);
					text_q.push_back(q);
				end
				queue_string(">");
				append_body(CH_LT);
				queue_string("</");
				append_name();
				queue_string(">");
			end
			6: begin
				queue_string($urandom_range(0, 1) ? "<?" : "<!");
				append_name();
				queue_string(" ");
				append_name();
				queue_string("?>");
			end
			// noise
			7: begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) begin
					text_q.push_back(8'($urandom_range(0, 255)));
				end
			end
			8: begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++) begin
					text_q.push_back($urandom_range(0, 1) ? CH_NL : CH_SPACE);
				end
			end
			default: begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) begin
					text_q.push_back(punct_set[$urandom_range(0, punct_set.len() - 1)]);
				end
			end
		endcase
	endtask

	// receiver with random stalls and two long hold-offs
	initial begin
		int hold;
		token_ready <= 1'b0;
		tokens_taken = 0;
		do @(posedge clk); while (!arst_n);
		forever begin
			hold = (tokens_taken == 100 || tokens_taken == 500) ? 300 : draw_idle();
			if (hold > 0) begin
				token_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			token_ready <= 1'b1;
			do @(posedge clk); while (!token_valid);
			tokens_taken++;
		end
	end

	// reset, stimulus and verdict
	initial begin
		in_item_t it;
		int n;
		int keep;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		items_sent = 0;
		punct_set = "<>?!/=[](),+-#|*&%;'\"";
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// extreme bytes, both unexpected in default mode
		it.char_in = 8'h00;
		it.end_of_text = 1'b0;
		send_byte(it);
		it.char_in = 8'hFF;
		send_byte(it);
		// identifier closed by newline, empty string, closer inside string,
		// text closed by '<', identifier flushed at end of text
		queue_string("<a:9\n''\"<\">\n<_-? b");
		flush_text();
		// text run flushed at end of text
		queue_string(">z");
		flush_text();
		// end of text while a quote has just opened string mode
		queue_string("'");
		flush_text();

		// random texts of well-formed fragments, noise and truncation
		while (items_sent < 1050) begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) begin
				append_fragment();
			end
			if ($urandom_range(0, 7) == 0) begin
				keep = $urandom_range(1, text_q.size());
				while (text_q.size() > keep) begin
					void'(text_q.pop_back());
				end
			end
			flush_text();
		end

		item_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (16) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
